@@ sv/coo_sparse_entry_store_defines.svh @@
`ifndef COO_SPARSE_ENTRY_STORE_DEFINES_SVH
`define COO_SPARSE_ENTRY_STORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define COO_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("coo_sparse_entry_store: assertion failed");

// The consequence must hold in the cycle after the antecedent.
`define COO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("coo_sparse_entry_store: assertion failed");

`else

`define COO_ASSERT(lbl, prop)

`define COO_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/coo_pkg.sv @@
package coo_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ROW_W    = 16;
    localparam int COL_W    = 16;
    localparam int VAL_W    = 32;
    localparam int EXT_W    = 17;
    localparam int CFG_IDX_W = 1;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COLS = 1'b1;

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                    done;
        logic                    hit;
        logic [ADDR_W-1:0]       hit_addr;
        logic signed [VAL_W-1:0] value;
    } t_scan_status;

endpackage

@@ sv/coo_ram.sv @@
module coo_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/coo_scan.sv @@
module coo_scan
    import coo_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_col,
    input  logic [CNT_W-1:0]  i_count,
    output logic [ADDR_W-1:0] o_raddr,
    input  t_entry            i_rdata,
    output t_scan_status      o_status
);

    typedef enum logic [1:0] {
        SC_IDLE = 2'b01,
        SC_RUN  = 2'b10
    } t_scan_state;

    t_scan_state       r_state, n_state;
    logic [CNT_W-1:0]  r_addr, n_addr;
    logic              r_cmp_vld, n_cmp_vld;
    logic [ADDR_W-1:0] r_cmp_addr;
    logic              issue;
    logic              hit;
    logic              done;

    assign issue = (r_state == SC_RUN) && (r_addr < i_count);
    assign hit   = r_cmp_vld && (i_rdata.row == i_row) && (i_rdata.col == i_col);
    assign done  = (r_state == SC_RUN) && (hit || (!issue && !r_cmp_vld));

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_cmp_vld = r_cmp_vld;
        unique case (r_state)
            SC_IDLE: begin
                if (i_start) begin
                    n_state   = SC_RUN;
                    n_addr    = '0;
                    n_cmp_vld = 1'b0;
                end
            end
            SC_RUN: begin
                n_addr    = r_addr + CNT_W'(issue);
                n_cmp_vld = issue;
                if (done) begin
                    n_state   = SC_IDLE;
                    n_cmp_vld = 1'b0;
                end
            end
            default: begin
                n_state = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SC_IDLE;
            r_addr    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_addr <= r_addr[ADDR_W-1:0];
    end

    assign o_raddr = r_addr[ADDR_W-1:0];

    always_comb begin
        o_status.done     = done;
        o_status.hit      = hit;
        o_status.hit_addr = r_cmp_addr;
        o_status.value    = i_rdata.value;
    end

endmodule

@@ sv/coo_sparse_entry_store.sv @@
// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    req_type, row_index, col_index, write_value
// result    out        o_out_valid / i_out_ready  read_value, extents, entries_used, store_full
// config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// A request that scans sweeps the stored entries through the single read port of the entry memory,
// one entry a cycle, and stops at the first hit or once all entries_used entries have been compared.
// A read outside the extents or a write of zero skips the scan and goes straight to ST_DONE.
// Synchronous active-low reset clears the count and both extents; the memory is not cleared.
// A new request is taken while a result waits; that request finishes only once the output is free.
`include "coo_sparse_entry_store_defines.svh"

module coo_sparse_entry_store
    import coo_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [EXT_W-1:0]           i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_req_type,
    input  logic [ROW_W-1:0]           i_row_index,
    input  logic [COL_W-1:0]           i_col_index,
    input  logic signed [VAL_W-1:0]    i_write_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [VAL_W-1:0]    o_read_value,
    output logic [EXT_W-1:0]           o_row_extent_now,
    output logic [EXT_W-1:0]           o_col_extent_now,
    output logic [CNT_W-1:0]           o_entries_used,
    output logic                       o_store_full
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [EXT_W-1:0]        r_row_ext, n_row_ext;
    logic [EXT_W-1:0]        r_col_ext, n_col_ext;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_out_valid, n_out_valid;
    logic                    r_req_type, n_req_type;
    logic [ROW_W-1:0]        r_req_row, n_req_row;
    logic [COL_W-1:0]        r_req_col, n_req_col;
    logic signed [VAL_W-1:0] r_req_value, n_req_value;
    logic signed [VAL_W-1:0] r_res_value, n_res_value;
    logic                    r_res_full, n_res_full;
    logic signed [VAL_W-1:0] r_out_value;
    logic [EXT_W-1:0]        r_out_row_ext;
    logic [EXT_W-1:0]        r_out_col_ext;
    logic [CNT_W-1:0]        r_out_count;
    logic                    r_out_full;

    logic                    accept;
    logic                    wr_nonzero;
    logic                    in_extent;
    logic [EXT_W-1:0]        row_need;
    logic [EXT_W-1:0]        col_need;
    logic                    scan_start;
    logic                    out_load;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    t_entry                  ram_wdata;
    t_entry                  ram_rdata;
    t_scan_status            scan_status;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign wr_nonzero = (i_req_type == REQ_WRITE) && (i_write_value != '0);
    assign row_need   = EXT_W'(i_row_index) + EXT_W'(1);
    assign col_need   = EXT_W'(i_col_index) + EXT_W'(1);
    assign in_extent  = (EXT_W'(i_row_index) < r_row_ext) && (EXT_W'(i_col_index) < r_col_ext);
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        ram_wdata.row   = r_req_row;
        ram_wdata.col   = r_req_col;
        ram_wdata.value = r_req_value;
    end

    always_comb begin
        n_state     = r_state;
        n_row_ext   = r_row_ext;
        n_col_ext   = r_col_ext;
        n_count     = r_count;
        n_req_type  = r_req_type;
        n_req_row   = r_req_row;
        n_req_col   = r_req_col;
        n_req_value = r_req_value;
        n_res_value = r_res_value;
        n_res_full  = r_res_full;
        n_out_valid = r_out_valid && !i_out_ready;
        scan_start  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = scan_status.hit_addr;

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_INITIAL_ROWS: n_row_ext = i_cfg_data;
                CFG_INITIAL_COLS: n_col_ext = i_cfg_data;
                default:          n_row_ext = r_row_ext;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_req_type  = i_req_type;
                    n_req_row   = i_row_index;
                    n_req_col   = i_col_index;
                    n_req_value = i_write_value;
                    n_res_value = '0;
                    n_res_full  = 1'b0;
                    if (wr_nonzero) begin
                        if (r_row_ext < row_need) begin
                            n_row_ext = row_need;
                        end
                        if (r_col_ext < col_need) begin
                            n_col_ext = col_need;
                        end
                    end
                    if (wr_nonzero || ((i_req_type == REQ_READ) && in_extent)) begin
                        scan_start = 1'b1;
                        n_state    = ST_SCAN;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_status.done) begin
                    n_state = ST_DONE;
                    if (r_req_type == REQ_WRITE) begin
                        if (scan_status.hit) begin
                            ram_we = 1'b1;
                        end else if (r_count < CNT_W'(CAPACITY)) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_count[ADDR_W-1:0];
                            n_count   = r_count + CNT_W'(1);
                        end else begin
                            n_res_full = 1'b1;
                        end
                    end else if (scan_status.hit) begin
                        n_res_value = scan_status.value;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_ext   <= '0;
            r_col_ext   <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_ext   <= n_row_ext;
            r_col_ext   <= n_col_ext;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type  <= n_req_type;
        r_req_row   <= n_req_row;
        r_req_col   <= n_req_col;
        r_req_value <= n_req_value;
        r_res_value <= n_res_value;
        r_res_full  <= n_res_full;
        if (out_load) begin
            r_out_value   <= r_res_value;
            r_out_row_ext <= r_row_ext;
            r_out_col_ext <= r_col_ext;
            r_out_count   <= r_count;
            r_out_full    <= r_res_full;
        end
    end

    coo_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_row    (r_req_row),
        .i_col    (r_req_col),
        .i_count  (r_count),
        .o_raddr  (ram_raddr),
        .i_rdata  (ram_rdata),
        .o_status (scan_status)
    );

    coo_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid      = r_out_valid;
    assign o_read_value     = r_out_value;
    assign o_row_extent_now = r_out_row_ext;
    assign o_col_extent_now = r_out_col_ext;
    assign o_entries_used   = r_out_count;
    assign o_store_full     = r_out_full;

    `COO_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `COO_ASSERT(a_full_only_at_capacity, !(o_out_valid && o_store_full) || (o_entries_used == CNT_W'(CAPACITY)))
    `COO_ASSERT(a_read_needs_entries, !(o_out_valid && (o_read_value != '0)) || (o_entries_used != '0))
    `COO_ASSERT_NEXT(a_busy_after_accept, accept, !o_in_ready)

endmodule
